[rtl/core/sparse_csr_matrix_multiply_top_defines.svh]
// Assertion macros shared by the sparse matrix product checker
`ifndef SPARSE_CSR_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define SPARSE_CSR_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SCMM_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SCMM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

[rtl/core/scmm_pkg.sv]
// Types and constants of the sparse CSR matrix product block
`timescale 1ns / 1ps
`default_nettype none
package scmm_pkg;

  localparam int PTR_W       = 11;
  localparam int COL_W       = 6;
  localparam int VAL_W       = 32;
  localparam int IDX_W       = 10;
  localparam int DIM_W       = 7;
  localparam int ENT_W       = COL_W + VAL_W;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [IN_TUSER_W-1:0] CMD_A_PTR   = 3'd0;
  localparam logic [IN_TUSER_W-1:0] CMD_A_ENTRY = 3'd1;
  localparam logic [IN_TUSER_W-1:0] CMD_B_PTR   = 3'd2;
  localparam logic [IN_TUSER_W-1:0] CMD_B_ENTRY = 3'd3;
  localparam logic [IN_TUSER_W-1:0] CMD_COMPUTE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [3:0] {
    S_IDLE, S_APTR1, S_APTR2, S_AENT, S_AWAIT, S_BPTR1, S_BPTR2, S_BENT,
    S_BWAIT, S_MUL, S_ACC, S_ERD, S_ERD2, S_ELOAD, S_OUT
  } state_t;

endpackage
`default_nettype wire

[rtl/core/scmm_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module scmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/sparse_csr_matrix_multiply_top.sv]
// Top level of the row-wise sparse CSR matrix product engine
//
//  channel | ports                        | carries
//  --------+------------------------------+--------------------------------------
//  input   | in_tvalid/in_tready/in_tdata | load pointer/entry or compute row
//  result  | out_tvalid/out_tready/out_*  | product entries of one row, tlast end
//  config  | cfg_valid/cfg_ready          | rows_a, inner_dim, cols_b
//
//  Load transactions are accepted back to back and do not stall the input.
//  A compute row is paced by the single multiplier/accumulator loop and the
//  one read port of each memory. rst_n is synchronous; no clearing pass.
//  in_tready drops for the whole row; a stalled result holds the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sparse_csr_matrix_multiply_top
  import scmm_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int MAX_NNZ  = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // index[9:0], column[15:10], entry_value[47:16], pointer[58:48], zero fill
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // command[2:0]
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // row[5:0], out_column[11:6], out_value[43:12], zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // entry_valid[0], error[1]
  output logic [OUT_TUSER_W-1:0]      out_tuser,
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data
);

  localparam int RAW = (MAX_ROWS + 1 > 1) ? $clog2(MAX_ROWS + 1) : 1;
  localparam int NAW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'(MAX_COLS);
  localparam logic [CNT_W-1:0] CNT_LIM  = CNT_W'(MAX_COLS);

  function automatic logic [PTR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] x);
    logic [PTR_W-1:0] r;
    r = x;
    if (int'(x) > MAX_NNZ) begin
      r = PTR_W'(MAX_NNZ);
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [DIM_W-1:0] nrows, ninner, ncols;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [PTR_W-1:0] p_r, p_nxt, pe_r, pe_nxt, q_r, q_nxt, qe_r, qe_nxt;
  logic [COL_W-1:0] j_r, j_nxt, k_r, k_nxt;
  logic [VAL_W-1:0] aval_r, aval_nxt, qprod_r, qprod_nxt;
  logic [2*VAL_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, t_r, t_nxt;
  logic [MAX_COLS-1:0] touched_r, touched_nxt;

  logic [COL_W-1:0] orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [VAL_W-1:0] oval_r, oval_nxt;
  logic ovalid_r, ovalid_nxt, olast_r, olast_nxt, oerr_r, oerr_nxt;

  logic [IDX_W-1:0] in_idx;
  logic [COL_W-1:0] in_col;
  logic [VAL_W-1:0] in_val;
  logic [PTR_W-1:0] in_ptr;
  logic in_acc;

  logic aptr_we, bptr_we, aent_we, bent_we, acc_we, lst_we;
  logic [RAW-1:0] aptr_ra, bptr_ra;
  logic [NAW-1:0] aent_ra, bent_ra;
  logic [CAW-1:0] acc_ra, lst_ra;
  logic [PTR_W-1:0] aptr_rd, bptr_rd;
  logic [ENT_W-1:0] aent_rd, bent_rd;
  logic [VAL_W-1:0] acc_rd, acc_wd;
  logic [COL_W-1:0] lst_rd;

  logic [VAL_W:0] sum;
  logic [VAL_W-1:0] sum_sat, mul_sat;
  logic [CAW-1:0] k_idx;

  assign in_idx = in_tdata[9:0];
  assign in_col = in_tdata[15:10];
  assign in_val = in_tdata[47:16];
  assign in_ptr = in_tdata[58:48];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign nrows  = (rows_a_r > ROWS_LIM) ? ROWS_LIM : rows_a_r;
  assign ninner = (inner_dim_r > ROWS_LIM) ? ROWS_LIM : inner_dim_r;
  assign ncols  = (cols_b_r > COLS_LIM) ? COLS_LIM : cols_b_r;
  assign k_idx  = CAW'(k_r);

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {4'b0, oval_r, ocol_r, orow_r};
  assign out_tuser  = {oerr_r, ovalid_r};
  assign out_tlast  = olast_r;

  assign sum = {acc_rd[VAL_W-1], acc_rd} + {qprod_r[VAL_W-1], qprod_r};
  assign sum_sat = (sum[VAL_W] != sum[VAL_W-1])
                 ? {sum[VAL_W], {(VAL_W-1){~sum[VAL_W]}}} : sum[VAL_W-1:0];
  assign mul_sat = (prod_r[63:47] == '0 || prod_r[63:47] == '1)
                 ? prod_r[47:16] : {prod_r[63], {(VAL_W-1){~prod_r[63]}}};

  scmm_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS + 1)) u_aptr (
    .clk, .we(aptr_we), .waddr(RAW'(in_idx)), .wdata(in_ptr),
    .raddr(aptr_ra), .rdata(aptr_rd));
  scmm_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS + 1)) u_bptr (
    .clk, .we(bptr_we), .waddr(RAW'(in_idx)), .wdata(in_ptr),
    .raddr(bptr_ra), .rdata(bptr_rd));
  scmm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NNZ)) u_aent (
    .clk, .we(aent_we), .waddr(NAW'(in_idx)), .wdata({in_col, in_val}),
    .raddr(aent_ra), .rdata(aent_rd));
  scmm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NNZ)) u_bent (
    .clk, .we(bent_we), .waddr(NAW'(in_idx)), .wdata({in_col, in_val}),
    .raddr(bent_ra), .rdata(bent_rd));
  scmm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_acc (
    .clk, .we(acc_we), .waddr(k_idx), .wdata(acc_wd),
    .raddr(acc_ra), .rdata(acc_rd));
  scmm_ram #(.WIDTH(COL_W), .DEPTH(MAX_COLS)) u_lst (
    .clk, .we(lst_we), .waddr(CAW'(cnt_r)), .wdata(k_r),
    .raddr(lst_ra), .rdata(lst_rd));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == CMD_COMPUTE) begin
          state_nxt = (in_idx >= {3'b0, nrows}) ? S_OUT : S_APTR1;
        end
      end
      S_APTR1: state_nxt = S_APTR2;
      S_APTR2: state_nxt = S_AENT;
      S_AENT: begin
        if (p_r < pe_r) begin
          state_nxt = S_AWAIT;
        end else if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_AWAIT: state_nxt = ({1'b0, aent_rd[ENT_W-1:VAL_W]} < ninner) ? S_BPTR1 : S_AENT;
      S_BPTR1: state_nxt = S_BPTR2;
      S_BPTR2: state_nxt = S_BENT;
      S_BENT:  state_nxt = (q_r < qe_r) ? S_BWAIT : S_AENT;
      S_BWAIT: state_nxt = ({1'b0, bent_rd[ENT_W-1:VAL_W]} < ncols) ? S_MUL : S_BENT;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = S_BENT;
      S_ERD:   state_nxt = S_ERD2;
      S_ERD2:  state_nxt = S_ELOAD;
      S_ELOAD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) begin
          state_nxt = olast_r ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    aptr_we = in_acc && in_tuser == CMD_A_PTR && int'(in_idx) <= MAX_ROWS;
    bptr_we = in_acc && in_tuser == CMD_B_PTR && int'(in_idx) <= MAX_ROWS;
    aent_we = in_acc && in_tuser == CMD_A_ENTRY && int'(in_idx) < MAX_NNZ;
    bent_we = in_acc && in_tuser == CMD_B_ENTRY && int'(in_idx) < MAX_NNZ;
    aptr_ra = (state_r == S_APTR1) ? RAW'(idx_r + 1'b1) : RAW'(in_idx);
    bptr_ra = (state_r == S_BPTR1) ? RAW'({1'b0, j_r} + 1'b1)
                                   : RAW'(aent_rd[ENT_W-1:VAL_W]);
    aent_ra = NAW'(p_r);
    bent_ra = NAW'(q_r);
    acc_ra  = (state_r == S_ERD2) ? CAW'(lst_rd) : k_idx;
    lst_ra  = CAW'(t_r);
    acc_we  = (state_r == S_ACC);
    acc_wd  = touched_r[k_idx] ? sum_sat : qprod_r;
    lst_we  = (state_r == S_ACC) && !touched_r[k_idx] && cnt_r < CNT_LIM;
  end

  always_comb begin
    idx_nxt = idx_r;  p_nxt = p_r;  pe_nxt = pe_r;  q_nxt = q_r;  qe_nxt = qe_r;
    j_nxt = j_r;  k_nxt = k_r;  aval_nxt = aval_r;  qprod_nxt = qprod_r;
    prod_nxt = prod_r;  cnt_nxt = cnt_r;  t_nxt = t_r;  touched_nxt = touched_r;
    orow_nxt = orow_r;  ocol_nxt = ocol_r;  oval_nxt = oval_r;
    ovalid_nxt = ovalid_r;  olast_nxt = olast_r;  oerr_nxt = oerr_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = in_idx;
        cnt_nxt = '0;
        t_nxt = '0;
        orow_nxt = '0;
        ocol_nxt = '0;
        oval_nxt = '0;
        ovalid_nxt = 1'b0;
        olast_nxt = 1'b1;
        oerr_nxt = 1'b1;
      end
      S_APTR1: p_nxt = clamp_ptr(aptr_rd);
      S_APTR2: pe_nxt = clamp_ptr(aptr_rd);
      S_AENT: begin
        orow_nxt = COL_W'(idx_r);
        oerr_nxt = 1'b0;
      end
      S_AWAIT: begin
        j_nxt = aent_rd[ENT_W-1:VAL_W];
        aval_nxt = aent_rd[VAL_W-1:0];
        p_nxt = p_r + 1'b1;
      end
      S_BPTR1: q_nxt = clamp_ptr(bptr_rd);
      S_BPTR2: qe_nxt = clamp_ptr(bptr_rd);
      S_BENT: begin
        if (q_r < qe_r) begin
          q_nxt = q_r + 1'b1;
        end
      end
      S_BWAIT: begin
        k_nxt = bent_rd[ENT_W-1:VAL_W];
        prod_nxt = $signed(aval_r) * $signed(bent_rd[VAL_W-1:0]);
      end
      S_MUL: qprod_nxt = mul_sat;
      S_ACC: begin
        if (!touched_r[k_idx]) begin
          touched_nxt[k_idx] = 1'b1;
          if (cnt_r < CNT_LIM) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      S_ERD2: k_nxt = lst_rd;
      S_ELOAD: begin
        ocol_nxt = k_r;
        oval_nxt = acc_rd;
        ovalid_nxt = 1'b1;
        olast_nxt = (CNT_W'(t_r + 1'b1) == cnt_r);
      end
      S_OUT: begin
        if (out_tready) begin
          t_nxt = t_r + 1'b1;
          if (ovalid_r) begin
            touched_nxt[k_idx] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_a_r <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      cols_b_r <= DIM_RESET;
      touched_r <= '0;
      cnt_r <= '0;
      t_r <= '0;
    end else begin
      state_r <= state_nxt;
      touched_r <= touched_nxt;
      cnt_r <= cnt_nxt;
      t_r <= t_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_A:    rows_a_r <= cfg_data;
          REG_INNER_DIM: inner_dim_r <= cfg_data;
          REG_COLS_B:    cols_b_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;  p_r <= p_nxt;  pe_r <= pe_nxt;  q_r <= q_nxt;  qe_r <= qe_nxt;
    j_r <= j_nxt;  k_r <= k_nxt;  aval_r <= aval_nxt;  qprod_r <= qprod_nxt;
    prod_r <= prod_nxt;
    orow_r <= orow_nxt;  ocol_r <= ocol_nxt;  oval_r <= oval_nxt;
    ovalid_r <= ovalid_nxt;  olast_r <= olast_nxt;  oerr_r <= oerr_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/scmm_checker.sv]
// Port-level checks of the sparse matrix product block and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_csr_matrix_multiply_top_defines.svh"
module scmm_checker
  import scmm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic [IN_TUSER_W-1:0]  in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser,
  input wire logic                   out_tlast,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic [CFG_IDX_W-1:0]   cfg_index,
  input wire logic [DIM_W-1:0]       cfg_data
);

  `SCMM_ASSERT_NOW(a_busy_excl, out_tvalid, !in_tready, "input taken while a result is pending")
  `SCMM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `SCMM_ASSERT_NOW(a_err_last, out_tvalid && out_tuser[1], out_tlast && !out_tuser[0], "error result not a lone marker")
  `SCMM_ASSERT_NOW(a_empty_last, out_tvalid && !out_tuser[0], out_tlast, "row marker not last")
  `SCMM_ASSERT_NEXT(a_load_ready, in_tvalid && in_tready && in_tuser != CMD_COMPUTE, in_tready, "load transaction stalled input")

endmodule

bind sparse_csr_matrix_multiply_top scmm_checker u_scmm_checker (.*);
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the row-wise sparse CSR matrix product engine
`timescale 1ns / 1ps
module tb_top;
  import scmm_pkg::*;

  typedef struct packed {
    logic [IN_TUSER_W-1:0] cmd;
    logic [9:0]            idx;
    logic [5:0]            col;
    logic [31:0]           val;
    logic [10:0]           ptr;
  } load_item_t;

  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] val;
    logic        valid;
    logic        last;
    logic        err;
  } product_t;

  logic                   clk = 0;
  logic                   rst_n = 0;
  logic                   in_tvalid = 0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DIM_W-1:0]       cfg_data = '0;

  sparse_csr_matrix_multiply_top dut (.*);

  // shadow matrix state and write tracking
  logic [10:0] a_ptr [0:64];
  logic [10:0] b_ptr [0:64];
  bit          a_ptr_set [0:64];
  bit          b_ptr_set [0:64];
  logic [5:0]  a_col [0:1023];
  logic [5:0]  b_col [0:1023];
  logic signed [31:0] a_val [0:1023];
  logic signed [31:0] b_val [0:1023];
  bit          a_ent_set [0:1023];
  bit          b_ent_set [0:1023];
  logic [6:0]  rows_cfg = DIM_RESET, inner_cfg = DIM_RESET, cols_cfg = DIM_RESET;

  load_item_t pending_items[$];
  product_t   expected_products[$];
  bit         calm = 0;
  int         errors = 0;
  int         products_seen = 0, rows_run = 0, bad_rows = 0;

  initial forever #6 clk = ~clk;

  initial begin
    #200ms;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int unsigned dim(logic [6:0] v);
    return (v > 64) ? 64 : v;
  endfunction

  function automatic int unsigned cptr(logic [10:0] p);
    return (p > 1024) ? 1024 : p;
  endfunction

  function automatic logic signed [31:0] sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic bit row_ready(int unsigned r);
    int unsigned s, e, j, qs, qe;
    if (r + 1 > 64 || !a_ptr_set[r] || !a_ptr_set[r+1]) return 0;
    s = cptr(a_ptr[r]);
    e = cptr(a_ptr[r+1]);
    for (int unsigned p = s; p < e; p++) begin
      if (!a_ent_set[p]) return 0;
      j = a_col[p];
      if (j >= dim(inner_cfg)) continue;
      if (!b_ptr_set[j] || !b_ptr_set[j+1]) return 0;
      qs = cptr(b_ptr[j]);
      qe = cptr(b_ptr[j+1]);
      for (int unsigned q = qs; q < qe; q++)
        if (!b_ent_set[q]) return 0;
    end
    return 1;
  endfunction

  function automatic void predict_row(int unsigned r);
    logic signed [31:0] acc [0:63];
    bit                 hit [0:63];
    int unsigned        order [$];
    int unsigned        s, e, j, k, qs, qe;
    longint             prod;
    logic signed [31:0] term;
    product_t           pr;
    foreach (hit[i]) hit[i] = 0;
    if (r >= dim(rows_cfg)) begin
      pr = '{row: 0, col: 0, val: 0, valid: 0, last: 1, err: 1};
      expected_products.push_back(pr);
      return;
    end
    s = cptr(a_ptr[r]);
    e = cptr(a_ptr[r+1]);
    for (int unsigned p = s; p < e; p++) begin
      j = a_col[p];
      if (j >= dim(inner_cfg)) continue;
      qs = cptr(b_ptr[j]);
      qe = cptr(b_ptr[j+1]);
      for (int unsigned q = qs; q < qe; q++) begin
        k = b_col[q];
        if (k >= dim(cols_cfg)) continue;
        prod = longint'(a_val[p]) * longint'(b_val[q]);
        term = sat(prod >>> 16);
        if (!hit[k]) begin
          hit[k] = 1;
          acc[k] = term;
          order.push_back(k);
        end else begin
          acc[k] = sat(longint'(acc[k]) + longint'(term));
        end
      end
    end
    if (order.size() == 0) begin
      pr = '{row: r[5:0], col: 0, val: 0, valid: 0, last: 1, err: 0};
      expected_products.push_back(pr);
      return;
    end
    foreach (order[t]) begin
      pr = '{row: r[5:0], col: order[t][5:0], val: acc[order[t]], valid: 1,
             last: (t == order.size() - 1), err: 0};
      expected_products.push_back(pr);
    end
  endfunction

  function automatic void issue(logic [2:0] cmd, int unsigned idx, int unsigned col,
                                logic [31:0] val, int unsigned ptr);
    load_item_t it;
    it = '{cmd: cmd, idx: idx[9:0], col: col[5:0], val: val, ptr: ptr[10:0]};
    case (cmd)
      CMD_A_PTR:   if (idx <= 64) begin a_ptr[idx] = it.ptr; a_ptr_set[idx] = 1; end
      CMD_B_PTR:   if (idx <= 64) begin b_ptr[idx] = it.ptr; b_ptr_set[idx] = 1; end
      CMD_A_ENTRY: begin a_col[idx] = it.col; a_val[idx] = val; a_ent_set[idx] = 1; end
      CMD_B_ENTRY: begin b_col[idx] = it.col; b_val[idx] = val; b_ent_set[idx] = 1; end
      CMD_COMPUTE: begin
        rows_run++;
        predict_row(it.idx);
      end
      default: ;
    endcase
    pending_items.push_back(it);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic void random_items(int n);
    int unsigned r, kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        issue(CMD_A_ENTRY, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
              : $urandom_range(0, 31), ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
              : $urandom_range(0, 7), rand_value(), $urandom_range(0, 2047));
      end else if (kind < 52) begin
        issue(CMD_B_ENTRY, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
              : $urandom_range(0, 31), ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
              : $urandom_range(0, 7), rand_value(), $urandom_range(0, 2047));
      end else if (kind < 72) begin
        issue($urandom_range(0, 1) ? CMD_A_PTR : CMD_B_PTR,
              ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 9),
              $urandom_range(0, 63), $urandom,
              ($urandom_range(0, 14) == 0) ? $urandom_range(1024, 2047)
              : $urandom_range(0, 24));
      end else if (kind < 95) begin
        r = $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0 || !row_ready(r)) begin
          r = $urandom_range(0, 1023);
          if (r < dim(rows_cfg) && !row_ready(r)) r = 64 + $urandom_range(0, 959);
        end
        issue(CMD_COMPUTE, r, $urandom_range(0, 63), $urandom, $urandom_range(0, 2047));
      end else begin
        issue($urandom_range(5, 7), $urandom_range(0, 1023), $urandom_range(0, 63),
              $urandom, $urandom_range(0, 2047));
      end
    end
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_products.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] id, logic [6:0] v);
    cfg_index <= id;
    cfg_data  <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (id)
      REG_ROWS_A:    rows_cfg = v;
      REG_INNER_DIM: inner_cfg = v;
      REG_COLS_B:    cols_cfg = v;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_dims(logic [6:0] r, logic [6:0] k, logic [6:0] c);
    drain();
    write_reg(REG_ROWS_A, r);
    write_reg(REG_INNER_DIM, k);
    write_reg(REG_COLS_B, c);
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    load_item_t it;
    if (!rst_n) begin
      in_tvalid <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_tdata  <= {5'b0, it.ptr, it.val, it.col, it.idx};
        in_tuser  <= it.cmd;
        in_tvalid <= 1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 18);
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
      if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 18);
    end
  end

  // monitor
  always @(posedge clk) begin
    product_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{row: out_tdata[5:0], col: out_tdata[11:6], val: out_tdata[43:12],
              valid: out_tuser[0], last: out_tlast, err: out_tuser[1]};
      products_seen++;
      if (expected_products.size() == 0) begin
        errors++;
        $display("%0t: unexpected product, actual %p", $time, got);
      end else begin
        want = expected_products.pop_front();
        if (got.valid && got.err == 0) bad_rows += 0;
        if (got.err) bad_rows++;
        if (got !== want) begin
          errors++;
          $display("%0t: product mismatch, expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  initial begin
    foreach (a_ptr_set[i]) begin a_ptr_set[i] = 0; b_ptr_set[i] = 0; end
    foreach (a_ent_set[i]) begin a_ent_set[i] = 0; b_ent_set[i] = 0; end
    repeat (7) @(posedge clk);
    rst_n <= 1;

    issue(CMD_A_PTR, 0, 0, 0, 0);
    issue(CMD_A_PTR, 1, 0, 0, 3);
    issue(CMD_A_PTR, 2, 0, 0, 3);
    issue(CMD_A_PTR, 3, 0, 0, 5);
    issue(CMD_A_PTR, 4, 0, 0, 2);
    issue(CMD_A_PTR, 65, 0, 0, 2047);
    issue(CMD_A_ENTRY, 0, 0, 32'h7fffffff, 0);
    issue(CMD_A_ENTRY, 1, 1, 32'hfffe8000, 0);
    issue(CMD_A_ENTRY, 2, 2, 32'h00010000, 0);
    issue(CMD_A_ENTRY, 3, 1, 32'h80000000, 0);
    issue(CMD_A_ENTRY, 4, 0, 32'h0, 0);
    issue(CMD_B_PTR, 0, 0, 0, 0);
    issue(CMD_B_PTR, 1, 0, 0, 2);
    issue(CMD_B_PTR, 2, 0, 0, 4);
    issue(CMD_B_PTR, 3, 0, 0, 4);
    issue(CMD_B_ENTRY, 0, 5, 32'h7fffffff, 0);
    issue(CMD_B_ENTRY, 1, 63, 32'h00008000, 0);
    issue(CMD_B_ENTRY, 2, 5, 32'h80000000, 0);
    issue(CMD_B_ENTRY, 3, 0, 32'h3, 0);
    issue(3'd5, 1023, 63, 32'hffffffff, 2047);
    issue(3'd6, 0, 0, 0, 0);
    issue(3'd7, 0, 0, 0, 0);
    for (int r = 0; r < 4; r++) issue(CMD_COMPUTE, r, 0, 0, 0);
    issue(CMD_COMPUTE, 64, 0, 0, 0);
    issue(CMD_COMPUTE, 1023, 0, 0, 0);
    random_items(40);

    set_dims(1, 1, 1);
    for (int r = 0; r < 2; r++)
      if (r >= dim(rows_cfg) || row_ready(r)) issue(CMD_COMPUTE, r, 0, 0, 0);
    random_items(30);
    set_dims(127, 127, 127);
    random_items(40);
    set_dims(0, 64, 64);
    issue(CMD_COMPUTE, 0, 0, 0, 0);
    set_dims(8, 3, 6);
    random_items(40);
    set_dims(64, 64, 64);
    calm = 1;
    random_items(40);
    drain();

    $display("ran %0d compute commands, checked %0d products (%0d out-of-range rows)",
             rows_run, products_seen, bad_rows);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
